>>> hdl/jtd_pkg.sv
// Shared types and constants for the JTAG TAP debug transport.
// No dependencies; every other file of the block imports this package.
package jtd_pkg;

    localparam int C_ADDR_BITS = 7;
    localparam int C_IR_LEN    = 5;
    localparam logic [31:0] C_ID_RESET = 32'h10e3_1913;

    // Field widths and bit positions of the DTM registers
    localparam int C_WORD_W        = 32;
    localparam int C_STATUS_W      = 2;
    localparam int C_DBUS_LOW_BITS = C_WORD_W + C_STATUS_W;   // op/status + data
    localparam int C_LEN_W         = 7;
    localparam int C_REQ_ADDR_W    = 7;
    localparam int C_ABITS_W       = 6;
    localparam int C_BIT_DMIRESET  = 16;
    localparam int C_BIT_HARDRESET = 17;

    // Instruction codes
    localparam logic [7:0] C_OP_IDCODE = 8'h01;
    localparam logic [7:0] C_OP_DTMCTL = 8'h10;
    localparam logic [7:0] C_OP_DBUS   = 8'h11;
    localparam logic [7:0] C_OP_BYPASS = 8'h1f;

    typedef enum logic [3:0] {
        TAP_RESET      = 4'd0,
        TAP_IDLE       = 4'd1,
        TAP_DR_SELECT  = 4'd2,
        TAP_DR_CAPTURE = 4'd3,
        TAP_DR_SHIFT   = 4'd4,
        TAP_DR_EXIT1   = 4'd5,
        TAP_DR_PAUSE   = 4'd6,
        TAP_DR_EXIT2   = 4'd7,
        TAP_DR_UPDATE  = 4'd8,
        TAP_IR_SELECT  = 4'd9,
        TAP_IR_CAPTURE = 4'd10,
        TAP_IR_SHIFT   = 4'd11,
        TAP_IR_EXIT1   = 4'd12,
        TAP_IR_PAUSE   = 4'd13,
        TAP_IR_EXIT2   = 4'd14,
        TAP_IR_UPDATE  = 4'd15
    } t_tap_state;

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_FAILED  = 2'd2,
        ST_BUSY    = 2'd3
    } t_dmi_status;

    // Per-state action flags from the TAP controller to the register file
    typedef struct packed {
        logic test_reset;
        logic dr_capture;
        logic dr_shift;
        logic dr_update;
        logic ir_capture;
        logic ir_shift;
        logic ir_update;
    } t_tap_dec;

    typedef struct packed {
        logic        force_reset;
        logic        mode_select;
        logic        serial_in;
        logic [31:0] response_data;
        logic        module_busy;
        logic        module_error;
    } t_in_word;

    typedef struct packed {
        logic        serial_out;
        logic        request_valid;
        logic        request_write;
        logic [6:0]  request_address;
        logic [31:0] request_data;
        logic        hard_reset;
    } t_out_word;

endpackage

>>> hdl/jtd_in_if.sv
// Input channel: one TCK tick word with valid/ready handshake.
// Depends on jtd_pkg for the word type.
interface jtd_in_if;
    import jtd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

>>> hdl/jtd_out_if.sv
// Output channel: one result word per tick with valid/ready handshake.
// Depends on jtd_pkg for the word type.
interface jtd_out_if;
    import jtd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

>>> hdl/jtd_tap_fsm.sv
// 16-state JTAG TAP controller with per-state action decode.
// Depends on jtd_pkg (t_tap_state, t_tap_dec).
module jtd_tap_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_force,
    input  logic              i_tms,
    output jtd_pkg::t_tap_dec o_dec
);
    import jtd_pkg::*;

    t_tap_state r_state;
    t_tap_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TAP_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_force) begin
            n_state = TAP_RESET;
        end else begin
            case (r_state)
                TAP_RESET:      n_state = i_tms ? TAP_RESET     : TAP_IDLE;
                TAP_IDLE:       n_state = i_tms ? TAP_DR_SELECT : TAP_IDLE;
                TAP_DR_SELECT:  n_state = i_tms ? TAP_IR_SELECT : TAP_DR_CAPTURE;
                TAP_DR_CAPTURE: n_state = i_tms ? TAP_DR_EXIT1  : TAP_DR_SHIFT;
                TAP_DR_SHIFT:   n_state = i_tms ? TAP_DR_EXIT1  : TAP_DR_SHIFT;
                TAP_DR_EXIT1:   n_state = i_tms ? TAP_DR_UPDATE : TAP_DR_PAUSE;
                TAP_DR_PAUSE:   n_state = i_tms ? TAP_DR_EXIT2  : TAP_DR_PAUSE;
                TAP_DR_EXIT2:   n_state = i_tms ? TAP_DR_UPDATE : TAP_DR_SHIFT;
                TAP_DR_UPDATE:  n_state = i_tms ? TAP_DR_SELECT : TAP_IDLE;
                TAP_IR_SELECT:  n_state = i_tms ? TAP_RESET     : TAP_IR_CAPTURE;
                TAP_IR_CAPTURE: n_state = i_tms ? TAP_IR_EXIT1  : TAP_IR_SHIFT;
                TAP_IR_SHIFT:   n_state = i_tms ? TAP_IR_EXIT1  : TAP_IR_SHIFT;
                TAP_IR_EXIT1:   n_state = i_tms ? TAP_IR_UPDATE : TAP_IR_PAUSE;
                TAP_IR_PAUSE:   n_state = i_tms ? TAP_IR_EXIT2  : TAP_IR_PAUSE;
                TAP_IR_EXIT2:   n_state = i_tms ? TAP_IR_UPDATE : TAP_IR_SHIFT;
                TAP_IR_UPDATE:  n_state = i_tms ? TAP_DR_SELECT : TAP_IDLE;
                default:        n_state = TAP_RESET;
            endcase
        end
    end

    // Action decode of the current state
    always_comb begin
        o_dec = '0;
        case (r_state)
            TAP_RESET:      o_dec.test_reset = 1'b1;
            TAP_DR_CAPTURE: o_dec.dr_capture = 1'b1;
            TAP_DR_SHIFT:   o_dec.dr_shift   = 1'b1;
            TAP_DR_UPDATE:  o_dec.dr_update  = 1'b1;
            TAP_IR_CAPTURE: o_dec.ir_capture = 1'b1;
            TAP_IR_SHIFT:   o_dec.ir_shift   = 1'b1;
            TAP_IR_UPDATE:  o_dec.ir_update  = 1'b1;
            default:        o_dec = '0;
        endcase
    end

    a_force_to_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_force |=> r_state == TAP_RESET)
        else $error("TAP did not return to test-logic-reset on forced reset");

    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_state))
        else $error("TAP state moved without a tick");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_dec))
        else $error("more than one TAP action decoded");

endmodule

>>> hdl/jtd_dtm_regs.sv
// DTM register file: instruction, DR shift register, bypass, DMI status,
// and the per-tick result word. Depends on jtd_pkg.
module jtd_dtm_regs #(
    parameter int ADDR_BITS = jtd_pkg::C_ADDR_BITS,
    parameter int IR_LEN    = jtd_pkg::C_IR_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  jtd_pkg::t_in_word  i_word,
    input  jtd_pkg::t_tap_dec  i_dec,
    input  logic [31:0]        i_id_code,
    output jtd_pkg::t_out_word o_result
);
    import jtd_pkg::*;

    localparam int DR_LEN = ADDR_BITS + C_DBUS_LOW_BITS;

    localparam logic [IR_LEN-1:0]  OP_IDCODE = IR_LEN'(C_OP_IDCODE);
    localparam logic [IR_LEN-1:0]  OP_DTMCTL = IR_LEN'(C_OP_DTMCTL);
    localparam logic [IR_LEN-1:0]  OP_DBUS   = IR_LEN'(C_OP_DBUS);
    localparam logic [IR_LEN-1:0]  OP_BYPASS = IR_LEN'(C_OP_BYPASS);

    localparam logic [C_LEN_W-1:0] LEN_ONE  = C_LEN_W'(1);
    localparam logic [C_LEN_W-1:0] LEN_WORD = C_LEN_W'(C_WORD_W);
    localparam logic [C_LEN_W-1:0] LEN_DBUS = C_LEN_W'(DR_LEN);

    logic [DR_LEN-1:0]    r_dr,        n_dr;
    logic [C_LEN_W-1:0]   r_len,       n_len;
    logic [IR_LEN-1:0]    r_ir,        n_ir;
    logic                 r_bypass,    n_bypass;
    logic                 r_busy_d,    n_busy_d;
    t_dmi_status          r_status,    n_status;
    logic [ADDR_BITS-1:0] r_last_addr, n_last_addr;

    logic [DR_LEN-1:0]    dr_shr;
    logic [C_LEN_W-1:0]   shift_pos;
    logic [C_WORD_W-1:0]  dtm_word;
    t_dmi_status          dbus_status;
    t_out_word            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr        <= DR_LEN'(C_ID_RESET);
            r_len       <= '0;
            r_ir        <= OP_IDCODE;
            r_bypass    <= 1'b0;
            r_busy_d    <= 1'b0;
            r_status    <= ST_SUCCESS;
            r_last_addr <= '0;
        end else if (i_step) begin
            r_dr        <= n_dr;
            r_len       <= n_len;
            r_ir        <= n_ir;
            r_bypass    <= n_bypass;
            r_busy_d    <= n_busy_d;
            r_status    <= n_status;
            r_last_addr <= n_last_addr;
        end
    end

    assign dr_shr    = r_dr >> 1;
    assign shift_pos = r_len - LEN_ONE;
    // dtmcontrol: status, abits, version 1
    assign dtm_word  = {20'b0, r_status, C_ABITS_W'(ADDR_BITS), 4'b0001};
    assign dbus_status = i_word.module_error ? ST_FAILED : r_status;

    always_comb begin
        n_dr        = r_dr;
        n_len       = r_len;
        n_ir        = r_ir;
        n_bypass    = r_bypass;
        n_busy_d    = i_word.module_busy;
        n_status    = r_status;
        n_last_addr = r_last_addr;
        res         = '0;
        res.serial_out = r_dr[0];

        if (i_word.force_reset) begin
            n_dr        = DR_LEN'(i_id_code);
            n_len       = '0;
            n_ir        = OP_IDCODE;
            n_bypass    = 1'b0;
            n_busy_d    = 1'b0;
            n_status    = ST_SUCCESS;
            n_last_addr = '0;
            res.serial_out = i_id_code[0];
        end else if (i_dec.test_reset) begin
            n_ir = OP_IDCODE;
        end else if (i_dec.dr_capture) begin
            case (r_ir)
                OP_IDCODE: begin
                    n_dr  = DR_LEN'(i_id_code);
                    n_len = LEN_WORD;
                end
                OP_DTMCTL: begin
                    n_dr  = {r_dr[DR_LEN-1:C_WORD_W], dtm_word};
                    n_len = LEN_WORD;
                end
                OP_DBUS: begin
                    if (i_word.module_error) begin
                        n_status = ST_FAILED;
                    end
                    n_dr  = {r_last_addr, i_word.response_data, dbus_status};
                    n_len = LEN_DBUS;
                end
                OP_BYPASS: begin
                    n_dr[0] = r_bypass;
                    n_len   = LEN_ONE;
                end
                default: ;
            endcase
        end else if (i_dec.dr_shift) begin
            if (r_len > LEN_ONE) begin
                // shift right, TDI enters at the top of the active length
                for (int i = 0; i < DR_LEN; i++) begin
                    n_dr[i] = (i == int'(shift_pos)) ? i_word.serial_in : dr_shr[i];
                end
            end else begin
                n_dr[0] = i_word.serial_in;
            end
        end else if (i_dec.dr_update) begin
            case (r_ir)
                OP_DTMCTL: begin
                    res.hard_reset = r_dr[C_BIT_HARDRESET];
                    if (r_dr[C_BIT_DMIRESET]) begin
                        n_status = ST_SUCCESS;
                    end
                end
                OP_BYPASS: begin
                    n_bypass = r_dr[0];
                end
                OP_DBUS: begin
                    // sticky error blocks requests until cleared via dmireset
                    if (r_status == ST_SUCCESS) begin
                        if (r_busy_d) begin
                            n_status = ST_BUSY;
                        end else begin
                            res.request_valid = |r_dr[C_STATUS_W-1:0];
                        end
                    end
                    res.request_write   = r_dr[1];
                    res.request_data    = r_dr[C_DBUS_LOW_BITS-1:C_STATUS_W];
                    n_last_addr         = r_dr[C_DBUS_LOW_BITS +: ADDR_BITS];
                    res.request_address = C_REQ_ADDR_W'(r_dr[C_DBUS_LOW_BITS +: ADDR_BITS]);
                end
                default: ;
            endcase
        end else if (i_dec.ir_capture) begin
            n_dr[IR_LEN-1:0] = {r_ir[IR_LEN-1:2], 2'b01};
        end else if (i_dec.ir_shift) begin
            n_dr[IR_LEN-1:0] = {i_word.serial_in, r_dr[IR_LEN-1:1]};
        end else if (i_dec.ir_update) begin
            n_ir = r_dr[IR_LEN-1:0];
        end
    end

    assign o_result = res;

    a_req_only_on_dbus_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.request_valid |->
            i_dec.dr_update && r_ir == OP_DBUS && r_status == ST_SUCCESS && !r_busy_d)
        else $error("DMI request outside a clean DBUS update");

    a_hard_only_on_dtm_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.hard_reset |-> i_dec.dr_update && r_ir == OP_DTMCTL)
        else $error("hard reset outside a DTMCONTROL update");

    a_busy_goes_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_word.force_reset && i_dec.dr_update && r_ir == OP_DBUS &&
        r_status == ST_SUCCESS && r_busy_d |=> r_status == ST_BUSY)
        else $error("busy DBUS update did not set the sticky busy status");

    a_force_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.force_reset |=>
            r_len == '0 && r_ir == OP_IDCODE && r_status == ST_SUCCESS)
        else $error("forced reset left DTM state behind");

endmodule

>>> hdl/jtag_tap_debug_transport_core.sv
// JTAG TAP with RISC-V style debug transport: one input word is one TCK tick
// (TMS, TDI, forced reset and the debug-module response) and yields exactly one
// result word (TDO and the DMI request / hard reset fields). Throughput is one
// word per clock while the output is not stalled: a word is captured in the
// input register at its accept edge, passes the TAP and DTM logic and is
// loaded into the result register, where it is valid, as soon as that register
// is empty or being taken. A stalled output holds the result register while
// one more word waits in the input register; input ready then follows output
// ready in the same cycle. The IDCODE value is to be written over i_cfg_we /
// i_cfg_wdata only while the block is idle; the block itself does not enforce
// this. Depends on jtd_pkg, jtd_in_if, jtd_out_if, jtd_tap_fsm and jtd_dtm_regs.
module jtag_tap_debug_transport_core #(
    parameter int ADDR_BITS = jtd_pkg::C_ADDR_BITS,
    parameter int IR_LEN    = jtd_pkg::C_IR_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    jtd_in_if.sink      i_in,
    jtd_out_if.source   o_out
);
    import jtd_pkg::*;

    // Input register stage
    logic      r_in_valid;
    t_in_word  r_in_word;

    // Result register stage
    logic      r_out_valid;
    t_out_word r_out_word;

    // IDCODE configuration register
    logic [31:0] r_id_code;

    logic      advance;   // input-stage word moves into the result register
    t_tap_dec  tap_dec;
    t_out_word result;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_code <= C_ID_RESET;
        end else if (i_cfg_we) begin
            r_id_code <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    // TAP controller: state advances once per word
    jtd_tap_fsm u_tap_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_force (r_in_word.force_reset),
        .i_tms   (r_in_word.mode_select),
        .o_dec   (tap_dec)
    );

    // IR, DR and DMI status; result word computed from the pre-tick state
    jtd_dtm_regs #(
        .ADDR_BITS (ADDR_BITS),
        .IR_LEN    (IR_LEN)
    ) u_dtm_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_word    (r_in_word),
        .i_dec     (tap_dec),
        .i_id_code (r_id_code),
        .o_result  (result)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.word  = r_out_word;

endmodule

>>> bench/jtag_tap_debug_transport_core_tb.sv
// Self-checking bench for jtag_tap_debug_transport_core: drives TCK tick words and checks
// every result word against a cycle-free TAP/DTM predictor kept in the bench.
// Depends on jtd_pkg, jtd_in_if, jtd_out_if and the core RTL.
module jtag_tap_debug_transport_core_tb;
    import jtd_pkg::*;

    // Instruction codes at the IR width of the block
    localparam logic [4:0] OP_IDCODE = C_OP_IDCODE[4:0];
    localparam logic [4:0] OP_DTMCTL = C_OP_DTMCTL[4:0];
    localparam logic [4:0] OP_DBUS   = C_OP_DBUS[4:0];
    localparam logic [4:0] OP_BYPASS = C_OP_BYPASS[4:0];
    localparam int         DR_W      = C_ADDR_BITS + 34;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    jtd_in_if  in_ch ();
    jtd_out_if out_ch ();

    jtag_tap_debug_transport_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Clock: period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tick words waiting to be driven, and predicted result words in accept order
    t_in_word  tck_ticks_q[$];
    t_out_word dtm_result_q[$];

    // Idle/stall odds in percent, changed between phases
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // Run bookkeeping
    int unsigned err_count;
    int unsigned words_checked;
    int unsigned dmi_requests;
    int unsigned hard_resets;
    int unsigned gen_ticks;
    logic [4:0]  gen_ir;     // instruction the generator believes is loaded

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the TAP and DTM registers
    // ------------------------------------------------------------------
    t_tap_state      p_tap;
    logic [6:0]      p_len;
    logic [DR_W-1:0] p_dr;
    logic            p_byp;
    logic            p_busy_d;
    t_dmi_status     p_sticky;
    logic [4:0]      p_ir;
    logic [6:0]      p_last_addr;
    logic [31:0]     p_idcode;

    // Test-logic-reset values; the IDCODE register itself survives
    function automatic void tap_dtm_clear();
        p_tap       = TAP_RESET;
        p_len       = '0;
        p_dr        = DR_W'(p_idcode);
        p_byp       = 1'b0;
        p_busy_d    = 1'b0;
        p_sticky    = ST_SUCCESS;
        p_ir        = OP_IDCODE;
        p_last_addr = '0;
    endfunction

    // Standard 16-state TAP transition
    function automatic t_tap_state tap_next(input t_tap_state s, input logic tms);
        case (s)
            TAP_RESET:      return tms ? TAP_RESET     : TAP_IDLE;
            TAP_IDLE:       return tms ? TAP_DR_SELECT : TAP_IDLE;
            TAP_DR_SELECT:  return tms ? TAP_IR_SELECT : TAP_DR_CAPTURE;
            TAP_DR_CAPTURE: return tms ? TAP_DR_EXIT1  : TAP_DR_SHIFT;
            TAP_DR_SHIFT:   return tms ? TAP_DR_EXIT1  : TAP_DR_SHIFT;
            TAP_DR_EXIT1:   return tms ? TAP_DR_UPDATE : TAP_DR_PAUSE;
            TAP_DR_PAUSE:   return tms ? TAP_DR_EXIT2  : TAP_DR_PAUSE;
            TAP_DR_EXIT2:   return tms ? TAP_DR_UPDATE : TAP_DR_SHIFT;
            TAP_DR_UPDATE:  return tms ? TAP_DR_SELECT : TAP_IDLE;
            TAP_IR_SELECT:  return tms ? TAP_RESET     : TAP_IR_CAPTURE;
            TAP_IR_CAPTURE: return tms ? TAP_IR_EXIT1  : TAP_IR_SHIFT;
            TAP_IR_SHIFT:   return tms ? TAP_IR_EXIT1  : TAP_IR_SHIFT;
            TAP_IR_EXIT1:   return tms ? TAP_IR_UPDATE : TAP_IR_PAUSE;
            TAP_IR_PAUSE:   return tms ? TAP_IR_EXIT2  : TAP_IR_PAUSE;
            TAP_IR_EXIT2:   return tms ? TAP_IR_UPDATE : TAP_IR_SHIFT;
            default:        return tms ? TAP_DR_SELECT : TAP_IDLE;    // update-IR
        endcase
    endfunction

    // One TCK tick: advances the predictor and returns the result word it causes
    function automatic t_out_word tap_dtm_step(input t_in_word w);
        t_out_word       r;
        logic [DR_W-1:0] cur;
        logic [DR_W-1:0] nxt;
        t_dmi_status     nst;
        t_dmi_status     st;
        r   = '0;
        cur = p_dr;
        nxt = cur;
        nst = p_sticky;
        if (w.force_reset) begin
            tap_dtm_clear();
            r.serial_out = p_dr[0];
            return r;
        end
        case (p_tap)
            TAP_RESET: begin
                p_ir = OP_IDCODE;
            end
            TAP_DR_CAPTURE: begin
                // unknown instructions leave the DR, length and status alone
                if (p_ir == OP_IDCODE) begin
                    nxt   = DR_W'(p_idcode);
                    p_len = 7'd32;
                end else if (p_ir == OP_DTMCTL) begin
                    nxt   = {cur[DR_W-1:32], 20'd0, p_sticky, 6'(C_ADDR_BITS), 4'h1};
                    p_len = 7'd32;
                end else if (p_ir == OP_DBUS) begin
                    st = p_sticky;
                    if (w.module_error) begin
                        nst = ST_FAILED;
                        st  = ST_FAILED;
                    end
                    nxt   = {p_last_addr, w.response_data, st};
                    p_len = 7'(DR_W);
                end else if (p_ir == OP_BYPASS) begin
                    nxt   = {cur[DR_W-1:1], p_byp};
                    p_len = 7'd1;
                end
            end
            TAP_DR_SHIFT: begin
                // short lengths only overwrite bit 0
                if (p_len > 7'd1) begin
                    nxt            = cur >> 1;
                    nxt[p_len - 1] = w.serial_in;
                end else begin
                    nxt[0] = w.serial_in;
                end
            end
            TAP_DR_UPDATE: begin
                if (p_ir == OP_DTMCTL) begin
                    r.hard_reset = cur[C_BIT_HARDRESET];
                    if (cur[C_BIT_DMIRESET])
                        nst = ST_SUCCESS;
                end else if (p_ir == OP_BYPASS) begin
                    p_byp = cur[0];
                end else if (p_ir == OP_DBUS) begin
                    // a sticky error blocks the request until dmireset
                    if (p_sticky != ST_SUCCESS)
                        nst = p_sticky;
                    else if (p_busy_d)
                        nst = ST_BUSY;
                    else
                        r.request_valid = |cur[1:0];
                    r.request_write   = cur[1];
                    r.request_data    = cur[33:2];
                    p_last_addr       = cur[DR_W-1:34];
                    r.request_address = cur[DR_W-1:34];
                end
            end
            TAP_IR_CAPTURE: begin
                nxt = {cur[DR_W-1:5], p_ir[4:2], 2'b01};
            end
            TAP_IR_SHIFT: begin
                nxt = {cur[DR_W-1:5], w.serial_in, cur[4:1]};
            end
            TAP_IR_UPDATE: begin
                p_ir = cur[4:0];
            end
            default: begin
            end
        endcase
        p_tap        = tap_next(p_tap, w.mode_select);
        p_dr         = nxt;
        p_busy_d     = w.module_busy;
        p_sticky     = nst;
        r.serial_out = cur[0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds tick words from the pending queue, predicts on accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                dtm_result_q.push_back(tap_dtm_step(in_ch.word));
            // a word on offer is held until taken
            if (!in_ch.valid || in_ch.ready) begin
                if (tck_ticks_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_ch.word  <= tck_ticks_q.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word against the oldest prediction
    // ------------------------------------------------------------------
    t_out_word exp_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (dtm_result_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: result word with nothing pending: %h", out_ch.word);
                end else begin
                    exp_word = dtm_result_q.pop_front();
                    words_checked++;
                    if (exp_word.request_valid)
                        dmi_requests++;
                    if (exp_word.hard_reset)
                        hard_resets++;
                    if (out_ch.word.serial_out      !== exp_word.serial_out
                     || out_ch.word.request_valid   !== exp_word.request_valid
                     || out_ch.word.request_write   !== exp_word.request_write
                     || out_ch.word.request_address !== exp_word.request_address
                     || out_ch.word.request_data    !== exp_word.request_data
                     || out_ch.word.hard_reset      !== exp_word.hard_reset) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("ERROR: word %0d tdo/vld/wr/addr/data/hrst exp %b/%b/%b/%h/%h/%b",
                                     words_checked,
                                     exp_word.serial_out, exp_word.request_valid,
                                     exp_word.request_write, exp_word.request_address,
                                     exp_word.request_data, exp_word.hard_reset);
                            $display("       got %b/%b/%b/%h/%h/%b",
                                     out_ch.word.serial_out, out_ch.word.request_valid,
                                     out_ch.word.request_write, out_ch.word.request_address,
                                     out_ch.word.request_data, out_ch.word.hard_reset);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders (they only fill the pending queue)
    // ------------------------------------------------------------------
    task automatic push_tick(input logic frc, input logic tms, input logic tdi);
        t_in_word w;
        w.force_reset  = frc;
        w.mode_select  = tms;
        w.serial_in    = tdi;
        // mostly random read data, sometimes the extremes
        case ($urandom_range(7))
            0:       w.response_data = '0;
            1:       w.response_data = '1;
            default: w.response_data = $urandom;
        endcase
        w.module_busy  = ($urandom_range(7) == 0);
        w.module_error = ($urandom_range(11) == 0);
        tck_ticks_q.push_back(w);
        gen_ticks++;
    endtask

    // Five TMS-high ticks reach test-logic-reset from anywhere, then park in idle
    task automatic tap_goto_idle();
        repeat (5) push_tick(1'b0, 1'b1, 1'($urandom));
        push_tick(1'b0, 1'b0, 1'($urandom));
        gen_ir = OP_IDCODE;
    endtask

    // Idle -> IR scan of a 5-bit code, LSB first -> back to idle
    task automatic ir_load(input logic [4:0] code);
        push_tick(1'b0, 1'b1, 1'($urandom));    // select-DR
        push_tick(1'b0, 1'b1, 1'($urandom));    // select-IR
        push_tick(1'b0, 1'b0, 1'($urandom));    // capture-IR
        push_tick(1'b0, 1'b0, 1'($urandom));    // shift-IR
        for (int i = 0; i < 5; i++)
            push_tick(1'b0, i == 4, code[i]);
        push_tick(1'b0, 1'b1, 1'($urandom));    // exit1 -> update
        push_tick(1'b0, 1'b0, 1'($urandom));    // update -> idle
        gen_ir = code;
    endtask

    // Idle -> DR scan of nbits, LSB first, optional pause after bit brk -> idle;
    // bits past the top of the DR pattern are random
    task automatic dr_scan(input int nbits, input logic [DR_W-1:0] bits, input int brk);
        logic is_last;
        logic tdi_bit;
        push_tick(1'b0, 1'b1, 1'($urandom));    // select-DR
        push_tick(1'b0, 1'b0, 1'($urandom));    // capture-DR
        push_tick(1'b0, 1'b0, 1'($urandom));    // shift-DR
        for (int i = 0; i < nbits; i++) begin
            is_last = (i == nbits - 1);
            tdi_bit = (i < DR_W) ? bits[i] : 1'($urandom);
            push_tick(1'b0, is_last || i == brk, tdi_bit);
            if (i == brk && !is_last) begin
                push_tick(1'b0, 1'b0, 1'($urandom));              // exit1 -> pause
                repeat ($urandom_range(3)) push_tick(1'b0, 1'b0, 1'($urandom));
                push_tick(1'b0, 1'b1, 1'($urandom));              // pause -> exit2
                push_tick(1'b0, 1'b0, 1'($urandom));              // exit2 -> shift
            end
        end
        push_tick(1'b0, 1'b1, 1'($urandom));    // exit1 -> update
        push_tick(1'b0, 1'b0, 1'($urandom));    // update -> idle
    endtask

    // One random operation: mostly well-formed scans, some noise
    task automatic random_op();
        int unsigned      pick;
        int               nbits;
        int               brk;
        logic [DR_W-1:0]  bits;
        pick = $urandom_range(99);
        if (pick < 25) begin
            pick = $urandom_range(99);
            if (pick < 40)      ir_load(OP_DBUS);
            else if (pick < 60) ir_load(OP_DTMCTL);
            else if (pick < 72) ir_load(OP_BYPASS);
            else if (pick < 80) ir_load(OP_IDCODE);
            else                ir_load(5'($urandom));
        end else if (pick < 82) begin
            bits = {9'($urandom), 32'($urandom)};
            if (gen_ir == OP_DBUS) begin
                nbits = DR_W;
                bits  = {7'($urandom), 32'($urandom), 2'($urandom)};
                if ($urandom_range(3) == 0)
                    bits[33:2] = $urandom_range(1) ? '1 : '0;
            end else if (gen_ir == OP_DTMCTL) begin
                nbits                 = 32;
                bits[C_BIT_DMIRESET]  = 1'($urandom_range(1));
                bits[C_BIT_HARDRESET] = ($urandom_range(3) == 0);
            end else if (gen_ir == OP_IDCODE) begin
                nbits = 32;
            end else if (gen_ir == OP_BYPASS) begin
                nbits = $urandom_range(1, 3);
            end else begin
                nbits = $urandom_range(1, 8);
            end
            // broken scans: wrong length
            if ($urandom_range(9) == 0)
                nbits = $urandom_range(1, 45);
            brk = ($urandom_range(3) == 0) ? $urandom_range(nbits - 1) : -1;
            dr_scan(nbits, bits, brk);
        end else begin
            // noise, then a clean return to idle
            repeat ($urandom_range(1, 8))
                push_tick($urandom_range(15) == 0, 1'($urandom), 1'($urandom));
            tap_goto_idle();
        end
    endtask

    // Wait until every tick has been taken and every result has come back
    task automatic wait_drained();
        while (tck_ticks_q.size() != 0 || in_ch.valid || dtm_result_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // IDCODE register write while the block is idle
    task automatic idcode_write(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        p_idcode     = value;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                input logic [31:0] idcode);
        wait_drained();
        idcode_write(idcode);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        gen_ticks     = 0;
        while (gen_ticks < 110)
            random_op();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_word w;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        src_idle_pct  = 6;
        snk_stall_pct = 59;
        err_count     = 0;
        words_checked = 0;
        dmi_requests  = 0;
        hard_resets   = 0;
        gen_ticks     = 0;
        gen_ir        = OP_IDCODE;
        p_idcode      = C_ID_RESET;
        tap_dtm_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with an all-ones IDCODE
        idcode_write('1);
        // forced reset with every other field at its maximum
        w = '1;
        tck_ticks_q.push_back(w);
        // quiet tick, all fields zero: reset -> idle
        w = '0;
        tck_ticks_q.push_back(w);
        // bypass path: load the instruction, scan three bits through it
        ir_load(OP_BYPASS);
        dr_scan(3, DR_W'(3'b101), -1);
        // TMS-driven return to test-logic-reset
        tap_goto_idle();

        // Random phases: sender idles lightly, then receiver, then neither
        random_phase(6, 59, 32'h0000_0000);
        random_phase(59, 6, $urandom);
        random_phase(0, 0, C_ID_RESET);

        wait_drained();
        $display("Checked %0d result words: %0d DMI requests, %0d hard resets,",
                 words_checked, dmi_requests, hard_resets);
        $display("IDCODE settings all-ones, zero, random and default, three idle mixes");
        if (err_count == 0 && dtm_result_q.size() == 0) begin
            $display("jtag_tap_debug_transport_core test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, dtm_result_q.size());
            $display("jtag_tap_debug_transport_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout: %0d words pending, %0d results missing",
                 tck_ticks_q.size(), dtm_result_q.size());
        $display("jtag_tap_debug_transport_core test failed");
        $finish;
    end

endmodule
